// ----- rtl/core/fde_pkg.sv -----
// ----------------------------------------------------------------------------
// fde_pkg
// Shared types, register codes and a Q15 helper for the feedback delay echo.
// ----------------------------------------------------------------------------
`default_nettype none

package fde_pkg;

	localparam int CFG_W           = 18;
	localparam int CFG_IDX_W       = 2;
	localparam int SAMPLE_W        = 16;
	localparam int Q15_ONE         = 32768;
	localparam int LENGTH_AT_RESET = 131072;
	localparam int FEEDBACK_LIMIT  = 31130;
	localparam int FEEDBACK_RESET  = 16384;
	localparam int MIX_LIMIT       = 32768;
	localparam int MIX_RESET       = 9830;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EFFECT_ON     = 2'd0,
		REG_DELAY_LENGTH  = 2'd1,
		REG_FEEDBACK_GAIN = 2'd2,
		REG_MIX_GAIN      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        effect_on;
		logic [14:0] feedback_gain;
		logic [15:0] mix_gain;
	} gains_t;

	// divide by 2^15 toward zero, then clamp to 16 bits
	function automatic sample_t q15_trunc_sat(input logic signed [32:0] v);
		logic signed [32:0] adj;
		logic signed [17:0] q;
		adj = v + (v[32] ? 33'sd32767 : 33'sd0);
		q   = 18'(adj >>> 15);
		if (q > 18'sd32767) begin
			return 16'sh7fff;
		end else if (q < -18'sd32768) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fde_if.sv -----
// ----------------------------------------------------------------------------
// fde_if
// Valid/ready sample channels into and out of the feedback delay echo.
// ----------------------------------------------------------------------------
`default_nettype none

interface fde_in_if;
	logic             valid;
	logic             ready;
	fde_pkg::sample_t in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink   (input valid, input in_sample, output ready);
endinterface

interface fde_out_if;
	logic             valid;
	logic             ready;
	fde_pkg::sample_t out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fde_ram.sv -----
// ----------------------------------------------------------------------------
// fde_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/fde_cfg.sv -----
// ----------------------------------------------------------------------------
// fde_cfg
// Configuration registers: range limiting and the delay length change pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_cfg #(
	parameter int MAX_DELAY_SAMPLES = 131072,
	parameter int LEN_W             = $clog2(MAX_DELAY_SAMPLES + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fde_pkg::CFG_W-1:0]       cfg_data,
	output fde_pkg::gains_t                      gains,
	output logic      [LEN_W-1:0]                delay_length,
	output logic                                 length_clear
);

	import fde_pkg::*;

	localparam int CMP_W     = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam int RESET_LEN = (LENGTH_AT_RESET > MAX_DELAY_SAMPLES) ?
	                           MAX_DELAY_SAMPLES : LENGTH_AT_RESET;

	gains_t           gains_q;
	logic [LEN_W-1:0] length_q;
	logic [CMP_W-1:0] len_raw;
	logic [LEN_W-1:0] len_lim;
	logic [14:0]      fb_lim;
	logic [15:0]      mix_lim;
	cfg_reg_t         reg_sel;

	assign reg_sel = cfg_reg_t'(cfg_index);
	assign len_raw = CMP_W'(cfg_data);

	always_comb begin
		if (len_raw == '0) begin
			len_lim = LEN_W'(1);
		end else if (len_raw > CMP_W'(MAX_DELAY_SAMPLES)) begin
			len_lim = LEN_W'(MAX_DELAY_SAMPLES);
		end else begin
			len_lim = LEN_W'(len_raw);
		end
	end

	assign fb_lim  = (cfg_data[14:0] > 15'(FEEDBACK_LIMIT)) ? 15'(FEEDBACK_LIMIT)
	                                                      : cfg_data[14:0];
	assign mix_lim = (cfg_data[15:0] > 16'(MIX_LIMIT)) ? 16'(MIX_LIMIT) : cfg_data[15:0];

	assign length_clear = cfg_we && (reg_sel == REG_DELAY_LENGTH) && (len_lim != length_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.effect_on     <= 1'b0;
			gains_q.feedback_gain <= 15'(FEEDBACK_RESET);
			gains_q.mix_gain      <= 16'(MIX_RESET);
			length_q              <= LEN_W'(RESET_LEN);
		end else if (cfg_we) begin
			case (reg_sel)
				REG_EFFECT_ON:     gains_q.effect_on     <= cfg_data[0];
				REG_DELAY_LENGTH:  length_q              <= len_lim;
				REG_FEEDBACK_GAIN: gains_q.feedback_gain <= fb_lim;
				REG_MIX_GAIN:      gains_q.mix_gain      <= mix_lim;
				default:           gains_q               <= gains_q;
			endcase
		end
	end

	assign gains        = gains_q;
	assign delay_length = length_q;

endmodule

`default_nettype wire

// ----- rtl/core/feedback_delay_echo.sv -----
// ----------------------------------------------------------------------------
// feedback_delay_echo
// Feedback delay-line echo with Q15 wet/dry mix over one delay RAM.
// ----------------------------------------------------------------------------
// pipeline: read, feedback, mix, sum and out stages from input beat to output beat
// throughput: one beat per cycle while the output is not stalled; with the effect on, a
//   beat waits for the write-back of the same delay entry, so a short length stalls input
// reset: registers to defaults, pointer zero; an entry not written since reset
//   or the last length change reads as silence, so there is no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_echo #(
	parameter int MAX_DELAY_SAMPLES = 131072
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fde_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fde_pkg::CFG_W-1:0]     cfg_data,
	fde_in_if.sink                             sample_in,
	fde_out_if.source                          sample_out
);

	import fde_pkg::*;

	localparam int AW    = $clog2(MAX_DELAY_SAMPLES);
	localparam int LEN_W = $clog2(MAX_DELAY_SAMPLES + 1);

	gains_t           gains;
	logic [LEN_W-1:0] delay_length;
	logic             length_clear;

	fde_cfg #(
		.MAX_DELAY_SAMPLES(MAX_DELAY_SAMPLES),
		.LEN_W(LEN_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.gains(gains),
		.delay_length(delay_length),
		.length_clear(length_clear)
	);

	// write pointer and fill state
	logic [AW-1:0] ptr_q;
	logic          wrapped_q;
	logic [AW:0]   ptr_inc;
	logic          ptr_wrap;

	// pipeline
	logic                 v_s1, v_s2, v_s3, v_s4, out_v_q;
	sample_t              x_s1, x_s2, x_s3, x_s4;
	logic [AW-1:0]        addr_s1, addr_s2;
	logic                 live_s1;
	sample_t              d_s1, d_s2;
	logic signed [31:0]   pfb_s2;
	logic signed [32:0]   pmd_s3, pmd_s4, pmx_s4;
	sample_t              out_sample_q;

	logic move1, move2, move3, move4;
	logic free1, free2, free3, free4, free_out;
	logic hazard, accept;

	logic [15:0]        rd_data;
	logic               ram_we;
	sample_t            fb_value;
	logic signed [32:0] fb_acc;
	logic signed [32:0] mix_acc;
	logic [16:0]        dry_w;

	assign free_out = !out_v_q || sample_out.ready;
	assign move4    = v_s4 && free_out;
	assign free4    = !v_s4 || move4;
	assign move3    = v_s3 && free4;
	assign free3    = !v_s3 || move3;
	assign move2    = v_s2 && free3;
	assign free2    = !v_s2 || move2;
	assign move1    = v_s1 && free2;
	assign free1    = !v_s1 || move1;

	// entry still waiting for its write-back
	assign hazard = gains.effect_on &&
	                ((v_s1 && (addr_s1 == ptr_q)) || (v_s2 && (addr_s2 == ptr_q)));

	assign sample_in.ready = free1 && !hazard;
	assign accept          = sample_in.valid && sample_in.ready;

	assign ptr_inc  = {1'b0, ptr_q} + (AW+1)'(1);
	assign ptr_wrap = ptr_inc >= (AW+1)'(delay_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (length_clear) begin
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (accept && gains.effect_on) begin
			if (ptr_wrap) begin
				ptr_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				ptr_q <= ptr_inc[AW-1:0];
			end
		end
	end

	fde_ram #(
		.WIDTH(16),
		.DEPTH(MAX_DELAY_SAMPLES),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(addr_s2),
		.wdata(fb_value),
		.re(accept && gains.effect_on),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	// entries not yet written since the last clear read as silence
	assign d_s1 = live_s1 ? sample_t'(rd_data) : '0;

	assign fb_acc   = (33'(x_s2) <<< 15) + 33'(pfb_s2);
	assign fb_value = q15_trunc_sat(fb_acc);
	assign ram_we   = move2 && gains.effect_on;

	assign dry_w   = 17'(Q15_ONE) - {1'b0, gains.mix_gain};
	assign mix_acc = pmd_s4 + pmx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= accept;
			end
			if (free2) begin
				v_s2 <= move1;
			end
			if (free3) begin
				v_s3 <= move2;
			end
			if (free4) begin
				v_s4 <= move3;
			end
			if (free_out) begin
				out_v_q <= move4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= sample_in.in_sample;
			addr_s1 <= ptr_q;
			live_s1 <= wrapped_q;
		end
		if (move1) begin
			x_s2    <= x_s1;
			addr_s2 <= addr_s1;
			d_s2    <= d_s1;
			pfb_s2  <= 32'(d_s1) * 32'($signed({1'b0, gains.feedback_gain}));
		end
		if (move2) begin
			x_s3   <= x_s2;
			pmd_s3 <= 33'(32'(d_s2) * 32'($signed({1'b0, gains.mix_gain})));
		end
		if (move3) begin
			x_s4   <= x_s3;
			pmd_s4 <= pmd_s3;
			pmx_s4 <= 33'(32'(x_s3) * 32'($signed({1'b0, dry_w})));
		end
		if (move4) begin
			out_sample_q <= gains.effect_on ? q15_trunc_sat(mix_acc) : x_s4;
		end
	end

	assign sample_out.valid      = out_v_q;
	assign sample_out.out_sample = out_sample_q;

endmodule

`default_nettype wire
